// ===== design/rpbu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the RGB pixel blend unit.
// No dependencies; every other design file refers to this package.
package rpbu_pkg;

	localparam int unsigned CH_NUM   = 3;
	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;

	// Blend opcodes; the two spare codes pass the top pixel through
	typedef enum logic [2:0] {
		OP_MUL    = 3'd0,
		OP_SUB    = 3'd1,
		OP_OVL    = 3'd2,
		OP_SCR    = 3'd3,
		OP_ADD    = 3'd4,
		OP_SCL    = 3'd5,
		OP_PASS_A = 3'd6,
		OP_PASS_B = 3'd7
	} op_t;

	// Register indexes on the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_OFFSET   = 3'd0,
		REG_GREEN_OFFSET = 3'd1,
		REG_BLUE_OFFSET  = 3'd2,
		REG_RED_GAIN     = 3'd3,
		REG_GREEN_GAIN   = 3'd4,
		REG_BLUE_GAIN    = 3'd5
	} reg_idx_t;

	// How the back end finishes a channel
	typedef enum logic [1:0] {
		K_DIRECT = 2'd0,  // result already known
		K_ROUND  = 2'd1,  // round(prod / 255)
		K_INV    = 2'd2,  // 255 - round(prod / 255)
		K_SAT    = 2'd3   // prod clamped to 255
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        dbl;     // product is doubled before rounding
		logic [15:0] prod;
		logic [7:0]  direct;
	} chan_mid_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] top_blue;
		logic [7:0] top_green;
		logic [7:0] top_red;
		logic [7:0] bottom_blue;
		logic [7:0] bottom_green;
		logic [7:0] bottom_red;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
	} pix_out_t;

endpackage

// ===== design/rpbu_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel items in and out.
// Depends on rpbu_pkg for the payload types.
interface rpbu_in_if;
	logic              valid;
	logic              ready;
	rpbu_pkg::pix_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rpbu_out_if;
	logic               valid;
	logic               ready;
	rpbu_pkg::pix_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rpbu_chan_mul.sv =====
`timescale 1ns / 1ps
// Channel front end: operand select, 8x8 multiply, direct results.
// Depends on rpbu_pkg.
module rpbu_chan_mul (
	input  rpbu_pkg::op_t      op,
	input  logic [7:0]         a,
	input  logic [7:0]         b,
	input  logic signed [8:0]  offset,
	input  logic [7:0]         gain,
	output rpbu_pkg::chan_mid_t mid
);

	logic [7:0]        ma;
	logic [7:0]        mb;
	logic signed [9:0] sum;

	assign sum = $signed({2'b00, a}) + $signed({offset[8], offset});

	always_comb begin
		ma         = a;
		mb         = b;
		mid.kind   = rpbu_pkg::K_DIRECT;
		mid.dbl    = 1'b0;
		mid.direct = a;
		case (op)
			rpbu_pkg::OP_MUL: begin
				mid.kind = rpbu_pkg::K_ROUND;
			end
			rpbu_pkg::OP_SUB: begin
				mid.direct = (a >= b) ? (a - b) : 8'd0;
			end
			rpbu_pkg::OP_OVL: begin
				mid.dbl = 1'b1;
				if (b[7]) begin
					// upper half: inverted doubled screen
					ma       = ~a;
					mb       = ~b;
					mid.kind = rpbu_pkg::K_INV;
				end else begin
					mid.kind = rpbu_pkg::K_ROUND;
				end
			end
			rpbu_pkg::OP_SCR: begin
				ma       = ~a;
				mb       = ~b;
				mid.kind = rpbu_pkg::K_INV;
			end
			rpbu_pkg::OP_ADD: begin
				if (sum[9])
					mid.direct = 8'd0;
				else if (sum[8])
					mid.direct = 8'hFF;
				else
					mid.direct = sum[7:0];
			end
			rpbu_pkg::OP_SCL: begin
				mb       = gain;
				mid.kind = rpbu_pkg::K_SAT;
			end
			default: begin
				mid.direct = a;
			end
		endcase
		mid.prod = 16'(ma * mb);
	end

endmodule

// ===== design/rpbu_chan_fin.sv =====
`timescale 1ns / 1ps
// Channel back end: rounded divide by 255, inversion, clamp.
// Depends on rpbu_pkg.
module rpbu_chan_fin (
	input  rpbu_pkg::chan_mid_t mid,
	output logic [7:0]          res
);

	logic [16:0] x;
	logic [17:0] est;
	logic [9:0]  q0;
	logic [17:0] r;
	logic [9:0]  q;
	logic [7:0]  rnd;

	// x/255 ~ (x + x/256 + 1) / 256, low by at most one; fix with remainder
	assign x   = (mid.dbl ? {mid.prod, 1'b0} : {1'b0, mid.prod}) + 17'd127;
	assign est = {1'b0, x} + {9'd0, x[16:8]} + 18'd1;
	assign q0  = est[17:8];
	assign r   = {1'b0, x} - {q0, 8'd0} + {8'd0, q0};
	assign q   = (r >= 18'd255) ? (q0 + 10'd1) : q0;
	assign rnd = q[7:0];

	always_comb begin
		case (mid.kind)
			rpbu_pkg::K_ROUND: res = rnd;
			rpbu_pkg::K_INV:   res = ~rnd;
			rpbu_pkg::K_SAT:   res = (|mid.prod[15:8]) ? 8'hFF : mid.prod[7:0];
			default:           res = mid.direct;
		endcase
	end

endmodule

// ===== design/rgb_pixel_blend_unit.sv =====
`timescale 1ns / 1ps
// RGB pixel blend unit: top level with config registers and pipeline.
// Depends on rpbu_pkg, rpbu_if, rpbu_chan_mul and rpbu_chan_fin.
//
// Usage:
//  - in_ch carries one item per pixel: opcode plus top and bottom RGB bytes.
//    out_ch returns one item per input item, in order: the three result bytes.
//  - Config registers (offsets, gains) are written through cfg_we/cfg_idx/
//    cfg_data, one register per cycle; write them only while the block is idle.
//    Unknown indexes are dropped.
//  - Two registers: input register, then per channel one 8x8 multiply and the
//    divide-by-255 logic feeding the result register. An accepted item is held
//    in the input register, then passes through the blend logic into the result
//    register, which drives out valid; throughput is one item per cycle while
//    out_ch is ready.
//  - Each register has its own valid bit and loads when it is empty or its
//    content moves on, so bubbles close up and in_ch stays ready while a
//    finished item waits on out_ch, until both registers are full.
//  - When the receiver stalls, out_ch holds its item and valid; up to two
//    items sit in the block before in_ch.ready drops.
//  - Reset (arst_n low) empties the pipe and sets offsets to 0, gains to 1.
module rgb_pixel_blend_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	rpbu_in_if.sink                           in_ch,
	rpbu_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [rpbu_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rpbu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned NCH = rpbu_pkg::CH_NUM;

	// config registers, indexed by channel
	logic signed [8:0] offset_q [NCH];
	logic [7:0]        gain_q   [NCH];

	// pipeline
	logic              v_s1, v_s2;
	logic              rdy_s1, rdy_s2;
	rpbu_pkg::pix_in_t in_s1;
	rpbu_pkg::op_t     op_s1;
	logic [7:0]        top_px [NCH];
	logic [7:0]        bot_px [NCH];
	rpbu_pkg::chan_mid_t mid_c  [NCH];
	logic [7:0]        res_c  [NCH];
	logic [7:0]        res_s2 [NCH];

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				offset_q[i] <= 9'sd0;
				gain_q[i]   <= 8'd1;
			end
		end else if (cfg_we) begin
			case (rpbu_pkg::reg_idx_t'(cfg_idx))
				rpbu_pkg::REG_RED_OFFSET:   offset_q[rpbu_pkg::CH_RED]   <= cfg_data;
				rpbu_pkg::REG_GREEN_OFFSET: offset_q[rpbu_pkg::CH_GREEN] <= cfg_data;
				rpbu_pkg::REG_BLUE_OFFSET:  offset_q[rpbu_pkg::CH_BLUE]  <= cfg_data;
				rpbu_pkg::REG_RED_GAIN:     gain_q[rpbu_pkg::CH_RED]     <= cfg_data[7:0];
				rpbu_pkg::REG_GREEN_GAIN:   gain_q[rpbu_pkg::CH_GREEN]   <= cfg_data[7:0];
				rpbu_pkg::REG_BLUE_GAIN:    gain_q[rpbu_pkg::CH_BLUE]    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// a stage may load when empty or when its item leaves this cycle
	assign rdy_s2      = !v_s2 || out_ch.ready;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_ch.valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid)
			in_s1 <= in_ch.data;
		if (rdy_s2 && v_s1)
			res_s2 <= res_c;
	end

	assign op_s1 = rpbu_pkg::op_t'(in_s1.opcode);

	assign top_px[rpbu_pkg::CH_RED]   = in_s1.top_red;
	assign top_px[rpbu_pkg::CH_GREEN] = in_s1.top_green;
	assign top_px[rpbu_pkg::CH_BLUE]  = in_s1.top_blue;
	assign bot_px[rpbu_pkg::CH_RED]   = in_s1.bottom_red;
	assign bot_px[rpbu_pkg::CH_GREEN] = in_s1.bottom_green;
	assign bot_px[rpbu_pkg::CH_BLUE]  = in_s1.bottom_blue;

	// same datapath for every channel
	for (genvar c = 0; c < NCH; c++) begin : g_ch
		rpbu_chan_mul u_mul (
			.op     (op_s1),
			.a      (top_px[c]),
			.b      (bot_px[c]),
			.offset (offset_q[c]),
			.gain   (gain_q[c]),
			.mid    (mid_c[c])
		);

		rpbu_chan_fin u_fin (
			.mid (mid_c[c]),
			.res (res_c[c])
		);
	end

	assign out_ch.valid          = v_s2;
	assign out_ch.data.out_red   = res_s2[rpbu_pkg::CH_RED];
	assign out_ch.data.out_green = res_s2[rpbu_pkg::CH_GREEN];
	assign out_ch.data.out_blue  = res_s2[rpbu_pkg::CH_BLUE];

endmodule

// ===== design/rpbu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RGB pixel blend unit, bound to the top level.
// Depends on rpbu_pkg and rgb_pixel_blend_unit.
module rpbu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input rpbu_pkg::pix_in_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input rpbu_pkg::pix_out_t out_data
);

	logic in_acc;
	logic pass_op;
	logic mul_white;

	assign in_acc    = in_valid && in_ready;
	assign pass_op   = (in_data.opcode == rpbu_pkg::OP_PASS_A)
		|| (in_data.opcode == rpbu_pkg::OP_PASS_B);
	assign mul_white = (in_data.opcode == rpbu_pkg::OP_MUL) && (in_data.top_red == 8'hFF);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out item changed while stalled");

	// spare opcodes pass the top pixel through
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && pass_op) ##1 out_ready |=>
		out_valid && (out_data.out_blue == $past(in_data.top_blue, 2))
		&& (out_data.out_red == $past(in_data.top_red, 2)))
		else $error("pass-through result wrong");

	// multiply by full white returns the bottom byte
	a_mul_white: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mul_white) ##1 out_ready |=>
		out_valid && (out_data.out_red == $past(in_data.bottom_red, 2)))
		else $error("multiply by white wrong");

endmodule

bind rgb_pixel_blend_unit rpbu_checker u_rpbu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_data   (in_ch.data),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

// ===== test/tb_rgb_pixel_blend_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_pixel_blend_unit: directed and random pixels,
// a built-in per-channel blend predictor, and random stalls on both channels.
// Depends on rpbu_pkg, rpbu_if and the rgb_pixel_blend_unit RTL.
module tb_rgb_pixel_blend_unit;
	import rpbu_pkg::*;

	// Register indexes with no register behind them; writes are dropped
	localparam logic [CFG_IDX_W-1:0] REG_NONE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_B = 3'd7;

	localparam int IDLE_LIMIT    = 2000;  // cycles with no item moving on either side
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 170;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rpbu_in_if  in_ch ();
	rpbu_out_if out_ch ();

	rgb_pixel_blend_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the adjust registers, indexed by CH_RED/CH_GREEN/CH_BLUE
	logic signed [8:0] offset_shadow [CH_NUM];
	logic [7:0]        gain_shadow   [CH_NUM];

	// Predicted result pixels, oldest first
	pix_out_t pending_pixels [$];

	int errors;
	int pixels_sent;
	int pixels_checked;
	int reg_writes;
	int idle_cycles;

	// Sender pacing
	int burst_left;
	bit steady_send;   // when set, the sender never inserts gaps

	// Receiver pacing
	int rx_cycle;
	int rx_mode;
	int stall_left;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor: one channel of one pixel
	// ------------------------------------------------------------------
	function automatic logic [7:0] blend_byte(logic [2:0] op, logic [7:0] a, logic [7:0] b,
			logic signed [8:0] offset, logic [7:0] gain);
		int ai;
		int bi;
		int inv_prod;
		int sum;
		ai = a;
		bi = b;
		inv_prod = (255 - ai) * (255 - bi);
		case (op)
			OP_MUL: return 8'((ai * bi + 127) / 255);
			OP_SUB: return (ai >= bi) ? 8'(ai - bi) : 8'd0;
			OP_OVL: begin
				// dark bottom doubles the multiply, bright bottom doubles the screen
				if (bi <= 127)
					return 8'((2 * ai * bi + 127) / 255);
				else
					return 8'(255 - (2 * inv_prod + 127) / 255);
			end
			OP_SCR: return 8'(255 - (inv_prod + 127) / 255);
			OP_ADD: begin
				sum = ai + int'(offset);
				if (sum < 0)
					return 8'd0;
				else if (sum > 255)
					return 8'd255;
				else
					return 8'(sum);
			end
			OP_SCL: begin
				sum = ai * int'(gain);
				return (sum > 255) ? 8'd255 : 8'(sum);
			end
			default: return a;  // spare opcodes: top pixel as is
		endcase
	endfunction

	function automatic pix_out_t predict_pixel(pix_in_t px);
		pix_out_t res;
		res.out_red   = blend_byte(px.opcode, px.top_red, px.bottom_red,
			offset_shadow[CH_RED], gain_shadow[CH_RED]);
		res.out_green = blend_byte(px.opcode, px.top_green, px.bottom_green,
			offset_shadow[CH_GREEN], gain_shadow[CH_GREEN]);
		res.out_blue  = blend_byte(px.opcode, px.top_blue, px.bottom_blue,
			offset_shadow[CH_BLUE], gain_shadow[CH_BLUE]);
		return res;
	endfunction

	function automatic pix_in_t make_pixel(logic [2:0] op,
			logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
			logic [7:0] br, logic [7:0] bg, logic [7:0] bb);
		pix_in_t px;
		px.opcode       = op;
		px.top_red      = tr;
		px.top_green    = tg;
		px.top_blue     = tb;
		px.bottom_red   = br;
		px.bottom_green = bg;
		px.bottom_blue  = bb;
		return px;
	endfunction

	// Bytes biased toward the interesting corners (0, 255, the overlay knee)
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127;
			3: return 8'd128;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pix_in_t random_pixel();
		int sel;
		logic [2:0] op;
		sel = $urandom_range(0, 19);
		// mostly the six real modes, now and then a spare code
		if (sel < 18)
			op = 3'(sel / 3);
		else
			op = (sel == 18) ? OP_PASS_A : OP_PASS_B;
		return make_pixel(op, pick_byte(), pick_byte(), pick_byte(),
			pick_byte(), pick_byte(), pick_byte());
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic report_error(string msg);
		errors++;
		if (errors <= 40)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Input side: record a prediction for every accepted item
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			pending_pixels.push_back(predict_pixel(in_ch.data));
			pixels_sent++;
		end
	end

	// ------------------------------------------------------------------
	// Output side: compare each accepted result with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pix_out_t want;
		pix_out_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (pending_pixels.size() == 0) begin
				report_error($sformatf("result r=%0d g=%0d b=%0d with nothing pending",
					got.out_red, got.out_green, got.out_blue));
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (got.out_red !== want.out_red)
					report_error($sformatf("item %0d out_red: want %0d got %0d",
						pixels_checked, want.out_red, got.out_red));
				if (got.out_green !== want.out_green)
					report_error($sformatf("item %0d out_green: want %0d got %0d",
						pixels_checked, want.out_green, got.out_green));
				if (got.out_blue !== want.out_blue)
					report_error($sformatf("item %0d out_blue: want %0d got %0d",
						pixels_checked, want.out_blue, got.out_blue));
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver backpressure: rotates through free-running, light random
	// stalls, long stalls and a fixed periodic pattern
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		rx_cycle++;
		rx_mode = (rx_cycle / 160) % 4;
		if (stall_left != 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else if (rx_mode == 2 && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(3, 10);
			out_ch.ready <= 1'b0;
		end else if (rx_mode == 3) begin
			out_ch.ready <= (rx_cycle % 5) != 0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run if nothing moves for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shared driving tasks
	// ------------------------------------------------------------------

	// Send one pixel; valid stays high across a burst, gaps fall between bursts
	task automatic send_pixel(pix_in_t px);
		if (burst_left == 0) begin
			if (!steady_send && $urandom_range(0, 2) != 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data  <= px;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Stop sending and wait until every predicted result has come back
	task automatic drain_pipe();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	// One register write; the shadow copy follows. Call only with the pipe empty.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		case (idx)
			REG_RED_OFFSET:   offset_shadow[CH_RED]   = value;
			REG_GREEN_OFFSET: offset_shadow[CH_GREEN] = value;
			REG_BLUE_OFFSET:  offset_shadow[CH_BLUE]  = value;
			REG_RED_GAIN:     gain_shadow[CH_RED]     = value[7:0];
			REG_GREEN_GAIN:   gain_shadow[CH_GREEN]   = value[7:0];
			REG_BLUE_GAIN:    gain_shadow[CH_BLUE]    = value[7:0];
			default: ;  // unmapped index: no register changes
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_regs(logic [8:0] ro, logic [8:0] go, logic [8:0] bo,
			logic [8:0] rg, logic [8:0] gg, logic [8:0] bg);
		drain_pipe();
		write_reg(REG_RED_OFFSET,   ro);
		write_reg(REG_GREEN_OFFSET, go);
		write_reg(REG_BLUE_OFFSET,  bo);
		write_reg(REG_RED_GAIN,     rg);
		write_reg(REG_GREEN_GAIN,   gg);
		write_reg(REG_BLUE_GAIN,    bg);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: zero offsets and unit gains leave the top pixel as is
	task automatic test_reset_defaults();
		send_pixel(make_pixel(OP_ADD, 8'd0, 8'd255, 8'd77, 8'd200, 8'd1, 8'd255));
		send_pixel(make_pixel(OP_SCL, 8'd255, 8'd0, 8'd128, 8'd9, 8'd255, 8'd0));
	endtask

	// Blend modes at the corners, the overlay knee and the spare opcodes
	task automatic test_blend_corners();
		send_pixel(make_pixel(OP_MUL, 8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd128));
		send_pixel(make_pixel(OP_MUL, 8'd1, 8'd254, 8'd127, 8'd1, 8'd1, 8'd129));
		send_pixel(make_pixel(OP_SUB, 8'd0, 8'd255, 8'd100, 8'd255, 8'd0, 8'd100));
		send_pixel(make_pixel(OP_SUB, 8'd255, 8'd3, 8'd99, 8'd255, 8'd4, 8'd100));
		send_pixel(make_pixel(OP_SCR, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd128));
		send_pixel(make_pixel(OP_SCR, 8'd255, 8'd1, 8'd200, 8'd255, 8'd254, 8'd60));
		// bottom exactly on either side of the knee
		send_pixel(make_pixel(OP_OVL, 8'd255, 8'd0, 8'd200, 8'd127, 8'd127, 8'd127));
		send_pixel(make_pixel(OP_OVL, 8'd255, 8'd0, 8'd200, 8'd128, 8'd128, 8'd128));
		send_pixel(make_pixel(OP_OVL, 8'd0, 8'd255, 8'd64, 8'd0, 8'd255, 8'd255));
		send_pixel(make_pixel(OP_PASS_A, 8'd12, 8'd255, 8'd0, 8'd99, 8'd0, 8'd255));
		send_pixel(make_pixel(OP_PASS_B, 8'd255, 8'd0, 8'd171, 8'd0, 8'd255, 8'd3));
	endtask

	// Offsets and gains at their extremes, plus writes to unmapped indexes
	task automatic test_adjust_regs();
		// max positive, max negative, and the one value below the range
		write_all_regs(9'sd255, -9'sd255, 9'h100, 9'd0, 9'd255, 9'h102);
		drain_pipe();
		write_reg(REG_NONE_A, 9'h1FF);
		write_reg(REG_NONE_B, 9'h000);
		send_pixel(make_pixel(OP_ADD, 8'd0, 8'd255, 8'd255, 8'd3, 8'd90, 8'd255));
		send_pixel(make_pixel(OP_ADD, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd7));
		// same top, different bottom: adjust modes must ignore the bottom pixel
		send_pixel(make_pixel(OP_ADD, 8'd1, 8'd254, 8'd200, 8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(OP_ADD, 8'd1, 8'd254, 8'd200, 8'd255, 8'd255, 8'd255));
		send_pixel(make_pixel(OP_SCL, 8'd255, 8'd1, 8'd127, 8'd0, 8'd255, 8'd0));
		send_pixel(make_pixel(OP_SCL, 8'd0, 8'd2, 8'd128, 8'd255, 8'd0, 8'd255));
		write_all_regs(-9'sd1, 9'd1, 9'sd255, 9'd1, 9'd2, 9'd0);
		send_pixel(make_pixel(OP_ADD, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(OP_SCL, 8'd255, 8'd128, 8'd127, 8'd0, 8'd0, 8'd0));
	endtask

	// Random pixels over several register settings, with gaps and stalls
	task automatic test_random_pixels();
		logic [8:0] ro;
		logic [8:0] go;
		logic [8:0] bo;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: write_all_regs(9'sd255, 9'sd255, 9'sd255, 9'd255, 9'd255, 9'd255);
				1: write_all_regs(9'h100, -9'sd255, 9'h100, 9'd0, 9'd0, 9'd0);
				default: begin
					ro = 9'($urandom);
					go = 9'($urandom);
					bo = 9'($urandom);
					write_all_regs(ro, go, bo, 9'($urandom), 9'($urandom), 9'($urandom));
					if ($urandom_range(0, 1) == 0)
						write_reg($urandom_range(0, 1) ? REG_NONE_A : REG_NONE_B, 9'($urandom));
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stretches of back-to-back sending every so often
				if (n % 60 == 0)
					steady_send = ($urandom_range(0, 2) == 0);
				// halfway through one phase, hold off until the pipe runs dry
				if (phase == 2 && n == PHASE_ITEMS / 2)
					drain_pipe();
				send_pixel(random_pixel());
			end
		end
		steady_send = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_data      = '0;
		in_ch.valid   = 1'b0;
		in_ch.data    = '0;
		out_ch.ready  = 1'b0;
		errors        = 0;
		pixels_sent   = 0;
		pixels_checked = 0;
		reg_writes    = 0;
		idle_cycles   = 0;
		burst_left    = 0;
		steady_send   = 1'b0;
		rx_cycle      = 0;
		rx_mode       = 0;
		stall_left    = 0;
		for (int c = 0; c < CH_NUM; c++) begin
			offset_shadow[c] = '0;
			gain_shadow[c]   = 8'd1;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_blend_corners();
		test_adjust_regs();
		test_random_pixels();

		// all results in, then wait to catch any stray output
		drain_pipe();
		repeat (8) @(posedge clk);

		$display("Sent %0d pixels over all six modes and both spare opcodes;", pixels_sent);
		$display("checked %0d results across %0d register writes.", pixels_checked, reg_writes);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
